[hdl/battery_level_estimator_top_defines.svh]
// Assertion macros shared by the battery level estimator RTL.
// No dependencies; included by the files that carry checks.
`ifndef BATTERY_LEVEL_ESTIMATOR_TOP_DEFINES_SVH
`define BATTERY_LEVEL_ESTIMATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication check.
`define BLE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Next-cycle implication check.
`define BLE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define BLE_ASSERT_NOW(label, clk, rstn, ante, cons)
`define BLE_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[hdl/ble_pkg.sv]
// Shared types and constants of the battery level estimator.
// No dependencies; imported by every module of the block.
package ble_pkg;

    localparam int SAMPLE_FIELDS        = 9;
    localparam int FIELD_W              = 12;
    localparam int SAMPLES_PER_ITEM_DEF = 9;
    localparam int ADC_BITS_DEF         = 12;
    localparam int VOLT_W               = 19;
    localparam int FRAC_BITS            = 16;
    localparam int PCT_W                = 7;
    localparam int ALPHA_W              = 16;
    localparam int HYST_W               = 7;
    localparam int CFG_DATA_W           = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 16'd9830;
    localparam logic [HYST_W-1:0]  HYST_RESET      = 7'd2;
    localparam logic               NOTIFY_EN_RESET = 1'b1;

    localparam logic [PCT_W-1:0]  PCT_FULL = 7'd100;
    localparam logic [PCT_W-1:0]  PCT_MID  = 7'd50;
    localparam logic [VOLT_W-1:0] VOLT_MAX = 19'd432537;

    typedef enum logic [1:0] {
        CFG_SMOOTH_WEIGHT = 2'd0,
        CFG_REPORT_HYST   = 2'd1,
        CFG_NOTIFY_EN     = 2'd2
    } cfg_index_t;

    typedef logic [FIELD_W-1:0] sample_t;

    typedef struct packed {
        sample_t sample_0;
        sample_t sample_1;
        sample_t sample_2;
        sample_t sample_3;
        sample_t sample_4;
        sample_t sample_5;
        sample_t sample_6;
        sample_t sample_7;
        sample_t sample_8;
        logic    sink_present;
        logic    link_connected;
    } in_item_t;

    typedef struct packed {
        logic [PCT_W-1:0]  percent;
        logic [VOLT_W-1:0] filtered_voltage;
        sample_t           median_sample;
        logic              report;
        logic              notify;
    } out_item_t;

    // load: stage register takes its input; take: a real item enters the stage
    typedef struct packed {
        logic load;
        logic take;
    } stage_ctl_t;

endpackage

[hdl/ble_rank_lane.sv]
// One median lane: ranks its own sample against all others of the item.
// Depends on ble_pkg.
module ble_rank_lane #(
    parameter int N      = ble_pkg::SAMPLES_PER_ITEM_DEF,
    parameter int SW     = ble_pkg::FIELD_W,
    parameter int RANK_W = $clog2(ble_pkg::SAMPLES_PER_ITEM_DEF),
    parameter int IDX    = 0
) (
    input  logic                  aclk,
    input  logic                  load,
    input  logic [N-1:0][SW-1:0]  samples,
    output logic [SW-1:0]         sample_reg,
    output logic [RANK_W-1:0]     rank_reg
);
    import ble_pkg::*;

    logic [RANK_W-1:0] rank_next;

    // Stable rank: ties go to the lower field index first.
    always_comb begin
        rank_next = '0;
        for (int j = 0; j < N; j++) begin
            if (j != IDX) begin
                if ((samples[j] < samples[IDX]) ||
                    ((samples[j] == samples[IDX]) && (j < IDX))) begin
                    rank_next = rank_next + RANK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sample_reg <= samples[IDX];
            rank_reg   <= rank_next;
        end
    end

endmodule

[hdl/ble_median_merge.sv]
// Merge stage: picks the lane whose rank is the middle one.
// Depends on ble_pkg.
module ble_median_merge #(
    parameter int N      = ble_pkg::SAMPLES_PER_ITEM_DEF,
    parameter int SW     = ble_pkg::FIELD_W,
    parameter int RANK_W = $clog2(ble_pkg::SAMPLES_PER_ITEM_DEF)
) (
    input  logic                     aclk,
    input  logic                     load,
    input  logic [N-1:0][SW-1:0]     samples,
    input  logic [N-1:0][RANK_W-1:0] ranks,
    output logic [SW-1:0]            median_reg
);
    import ble_pkg::*;

    localparam int                MID      = N / 2;
    localparam logic [RANK_W-1:0] MID_RANK = RANK_W'(MID);

    logic [SW-1:0] median_next;

    // Ranks form a permutation, so exactly one lane hits.
    always_comb begin
        median_next = '0;
        for (int i = 0; i < N; i++) begin
            if (ranks[i] == MID_RANK) begin
                median_next = median_next | samples[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            median_reg <= median_next;
        end
    end

endmodule

[hdl/ble_volt_scale.sv]
// Two-stage scaling of the median code to Q3.16 volts: raw * 6.6 / full scale.
// Reciprocal estimate, then one compare-and-increment correction. Depends on ble_pkg.
module ble_volt_scale #(
    parameter int ADC_BITS = ble_pkg::ADC_BITS_DEF,
    parameter int SW       = ble_pkg::FIELD_W
) (
    input  ble_pkg::stage_ctl_t      est_ctl,
    input  ble_pkg::stage_ctl_t      fix_ctl,
    input  logic                     aclk,
    input  logic [SW-1:0]            median,
    output logic [ble_pkg::VOLT_W-1:0] volt_reg,
    output logic [SW-1:0]            median_reg
);
    import ble_pkg::*;

    localparam logic [63:0] SCALE_K     = 64'd33;
    localparam logic [63:0] SCALE_NUM   = SCALE_K << FRAC_BITS;
    localparam logic [63:0] SCALE_DEN   = 64'd5 * ((64'd1 << ADC_BITS) - 64'd1);
    localparam logic [63:0] SCALE_RECIP = (SCALE_NUM << ADC_BITS) / SCALE_DEN;
    localparam int          DEN_W       = ADC_BITS + 3;
    localparam int          PROD_W      = SW + VOLT_W;
    localparam int          CHK_W       = VOLT_W + 1 + DEN_W;

    localparam logic [VOLT_W-1:0] RECIP = SCALE_RECIP[VOLT_W-1:0];
    localparam logic [DEN_W-1:0]  DEN   = SCALE_DEN[DEN_W-1:0];
    localparam logic [CHK_W-1:0]  KMUL  = SCALE_K[CHK_W-1:0];

    logic [PROD_W-1:0] est_prod;
    logic [PROD_W-1:0] est_shift;
    logic [VOLT_W-1:0] est_next;
    logic [VOLT_W-1:0] est_reg;
    logic [SW-1:0]     med_est_reg;
    logic [VOLT_W-1:0] est_inc;
    logic [CHK_W-1:0]  chk_lhs;
    logic [CHK_W-1:0]  chk_rhs;
    logic [VOLT_W-1:0] volt_next;

    // Estimate is the exact quotient or one below it.
    always_comb begin
        est_prod  = PROD_W'(median) * PROD_W'(RECIP);
        est_shift = est_prod >> ADC_BITS;
        est_next  = est_shift[VOLT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (est_ctl.load) begin
            est_reg     <= est_next;
            med_est_reg <= median;
        end
    end

    // Bump the estimate when one more step still fits under raw * 33 << 16.
    always_comb begin
        est_inc   = est_reg + VOLT_W'(1);
        chk_lhs   = CHK_W'(est_inc) * CHK_W'(DEN);
        chk_rhs   = (CHK_W'(med_est_reg) * KMUL) << FRAC_BITS;
        volt_next = (chk_lhs <= chk_rhs) ? est_inc : est_reg;
    end

    always_ff @(posedge aclk) begin
        if (fix_ctl.load) begin
            volt_reg   <= volt_next;
            median_reg <= med_est_reg;
        end
    end

endmodule

[hdl/ble_level_track.sv]
// EMA filter, percent mapping and report hysteresis, one stage each.
// Holds the filter and report state. Depends on ble_pkg.
module ble_level_track (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ble_pkg::stage_ctl_t          ema_ctl,
    input  ble_pkg::stage_ctl_t          pct_ctl,
    input  ble_pkg::stage_ctl_t          out_ctl,
    input  logic [ble_pkg::ALPHA_W-1:0]  smooth_weight,
    input  logic [ble_pkg::HYST_W-1:0]   report_hysteresis,
    input  logic                         notify_enable,
    input  logic [ble_pkg::VOLT_W-1:0]   volt_in,
    input  ble_pkg::sample_t             median_in,
    input  logic                         sink_present,
    input  logic                         link_connected,
    output ble_pkg::out_item_t           out_reg
);
    import ble_pkg::*;

    localparam int              ACC_W      = VOLT_W + FRAC_BITS + 2;
    localparam int              PW         = 24;
    localparam logic [PW-1:0]   HI_LIMIT   = 24'd5439488;  // 20x vs 83 << 16
    localparam logic [PW-1:0]   LO_LIMIT   = 24'd2162688;  // 10x vs 33 << 16
    localparam logic [PW-1:0]   MID_LIMIT  = 24'd1245184;  // 5x vs 19 << 16
    localparam logic [19:0]     DIV7_MUL   = 20'd293;      // exact /7 below 682
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

    // ---- EMA stage ----
    logic [VOLT_W-1:0]        ema_reg;
    logic                     seeded_reg;
    sample_t                  med_ema_reg;
    logic signed [VOLT_W:0]   ema_delta;
    logic signed [ALPHA_W:0]  alpha_s;
    logic signed [ACC_W-1:0]  ema_prod;
    logic [ACC_W-1:0]         ema_acc;
    logic [VOLT_W-1:0]        ema_next;

    always_comb begin
        ema_delta = $signed({1'b0, volt_in}) - $signed({1'b0, ema_reg});
        alpha_s   = $signed({1'b0, smooth_weight});
        ema_prod  = alpha_s * ema_delta;
        ema_acc   = {2'b00, ema_reg, {FRAC_BITS{1'b0}}} + ema_prod + ROUND_HALF;
        ema_next  = seeded_reg ? ema_acc[FRAC_BITS +: VOLT_W] : volt_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ema_reg    <= '0;
            seeded_reg <= 1'b0;
        end else if (ema_ctl.take) begin
            ema_reg    <= ema_next;
            seeded_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ema_ctl.load) begin
            med_ema_reg <= median_in;
        end
    end

    // ---- percent stage ----
    logic [PW-1:0]      x20, x10, x5;
    logic [PW-1:0]      hi_diff, hi_scaled, lo_diff, lo_scaled;
    logic [10:0]        hi_u;
    logic [19:0]        hi_q;
    logic [PCT_W-1:0]   pct_next;
    logic [PCT_W-1:0]   pct_reg;
    logic [VOLT_W-1:0]  ema_pct_reg;
    sample_t            med_pct_reg;

    always_comb begin
        x20       = PW'(ema_reg) * PW'(20);
        x10       = PW'(ema_reg) * PW'(10);
        x5        = PW'(ema_reg) * PW'(5);
        // upper segment: 50 + (5x - 19) * 200 / 7, split as >> 13 then / 7
        hi_diff   = x5 - MID_LIMIT;
        hi_scaled = hi_diff * PW'(25);
        hi_u      = hi_scaled[23:13];
        hi_q      = 20'(hi_u) * DIV7_MUL;
        // lower segment: (10x - 33) * 10
        lo_diff   = x10 - LO_LIMIT;
        lo_scaled = lo_diff * PW'(10);
        if (x20 >= HI_LIMIT) begin
            pct_next = PCT_FULL;
        end else if (x10 <= LO_LIMIT) begin
            pct_next = '0;
        end else if (x5 > MID_LIMIT) begin
            pct_next = PCT_MID + hi_q[17:11];
        end else begin
            pct_next = lo_scaled[22:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (pct_ctl.load) begin
            pct_reg     <= pct_next;
            ema_pct_reg <= ema_reg;
            med_pct_reg <= med_ema_reg;
        end
    end

    // ---- report stage ----
    logic [PCT_W-1:0] last_reported_reg;
    logic             reported_once_reg;
    logic [PCT_W-1:0] pct_diff;
    logic             rep_fire;
    out_item_t        out_next;

    always_comb begin
        pct_diff = (pct_reg >= last_reported_reg) ? (pct_reg - last_reported_reg)
                                                  : (last_reported_reg - pct_reg);
        rep_fire = (!reported_once_reg || (pct_diff >= report_hysteresis)) && sink_present;
        out_next.percent          = pct_reg;
        out_next.filtered_voltage = ema_pct_reg;
        out_next.median_sample    = med_pct_reg;
        out_next.report           = rep_fire;
        out_next.notify           = rep_fire && notify_enable && link_connected;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reported_reg <= '0;
            reported_once_reg <= 1'b0;
        end else if (out_ctl.take && rep_fire) begin
            last_reported_reg <= pct_reg;
            reported_once_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ctl.load) begin
            out_reg <= out_next;
        end
    end

endmodule

[hdl/battery_level_estimator_top.sv]
// Battery level estimator: median of the sample beat, Q3.16 volts, EMA, percent, report.
// Depends on ble_pkg, ble_rank_lane, ble_median_merge, ble_volt_scale, ble_level_track.
//
// One input beat carries nine raw ADC codes and two status bits; one result beat comes
// back for each, in order. The block accepts a beat every clock cycle unless a stalled
// output holds it back; results pass the rank lanes, median merge, two scaling stages,
// EMA, percent and report/output register in turn. Each stage holds its own valid bit
// and loads whenever it is empty or its successor moves, so bubbles collapse and a
// stalled result does not block input until all seven stages are full. The rate is set
// by the two feedback loops, the EMA update and the report hysteresis, each closing around one stage.
// The median comes from one ranking lane per sample: each lane counts the samples below
// its own (ties broken by field order) and the merge stage picks the middle rank.
// Configuration writes (EMA alpha, report hysteresis, notify enable) are taken at once;
// write them only while no beat is in flight. Filter and report state clear on reset.
module battery_level_estimator_top #(
    parameter int SAMPLES_PER_ITEM = ble_pkg::SAMPLES_PER_ITEM_DEF,
    parameter int ADC_BITS         = ble_pkg::ADC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ble_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ble_pkg::out_item_t                m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  ble_pkg::cfg_index_t               cfg_index,
    input  logic [ble_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ble_pkg::*;

`include "battery_level_estimator_top_defines.svh"

    localparam int SW     = (ADC_BITS < FIELD_W) ? ADC_BITS : FIELD_W;
    localparam int RANK_W = $clog2(SAMPLES_PER_ITEM);

    // pipeline stage positions
    localparam int ST_RANK   = 0;
    localparam int ST_MEDIAN = 1;
    localparam int ST_EST    = 2;
    localparam int ST_FIX    = 3;
    localparam int ST_EMA    = 4;
    localparam int ST_PCT    = 5;
    localparam int ST_OUT    = 6;
    localparam int NST       = 7;

    function automatic sample_t sample_at(in_item_t item, int idx);
        case (idx)
            0:       return item.sample_0;
            1:       return item.sample_1;
            2:       return item.sample_2;
            3:       return item.sample_3;
            4:       return item.sample_4;
            5:       return item.sample_5;
            6:       return item.sample_6;
            7:       return item.sample_7;
            8:       return item.sample_8;
            default: return '0;
        endcase
    endfunction

    // ---- configuration registers ----
    logic [ALPHA_W-1:0] alpha_reg;
    logic [HYST_W-1:0]  hyst_reg;
    logic               notify_en_reg;

    assign cfg_ready = 1'b1;

    // Writes beyond the register list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg     <= ALPHA_RESET;
            hyst_reg      <= HYST_RESET;
            notify_en_reg <= NOTIFY_EN_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SMOOTH_WEIGHT: alpha_reg     <= cfg_data[ALPHA_W-1:0];
                CFG_REPORT_HYST:   hyst_reg      <= cfg_data[HYST_W-1:0];
                CFG_NOTIFY_EN:     notify_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---- stage valid bits and load enables ----
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_in;
    logic [NST-1:0] stage_load;
    logic [NST-1:0] stage_take;
    stage_ctl_t     ctl [NST];

    // A stage loads when empty or when the stage after it advances.
    always_comb begin
        stage_load[NST-1] = !vld_reg[NST-1] || m_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            stage_load[k] = !vld_reg[k] || stage_load[k+1];
        end
        vld_in     = {vld_reg[NST-2:0], s_valid};
        stage_take = stage_load & vld_in;
        for (int k = 0; k < NST; k++) begin
            ctl[k].load = stage_load[k];
            ctl[k].take = stage_take[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= (stage_load & vld_in) | (~stage_load & vld_reg);
        end
    end

    assign s_ready = stage_load[ST_RANK];
    assign m_valid = vld_reg[ST_OUT];

    // ---- status flags travel alongside the datapath up to the report stage ----
    logic [ST_PCT:0] sink_reg;
    logic [ST_PCT:0] link_reg;

    always_ff @(posedge aclk) begin
        if (stage_load[ST_RANK]) begin
            sink_reg[ST_RANK] <= s_data.sink_present;
            link_reg[ST_RANK] <= s_data.link_connected;
        end
        for (int k = ST_MEDIAN; k <= ST_PCT; k++) begin
            if (stage_load[k]) begin
                sink_reg[k] <= sink_reg[k-1];
                link_reg[k] <= link_reg[k-1];
            end
        end
    end

    // ---- ranking lanes: one per sample, upper bits beyond the ADC width dropped ----
    logic [SAMPLES_PER_ITEM-1:0][SW-1:0]     lane_x;
    logic [SAMPLES_PER_ITEM-1:0][SW-1:0]     lane_sample;
    logic [SAMPLES_PER_ITEM-1:0][RANK_W-1:0] lane_rank;

    always_comb begin
        for (int i = 0; i < SAMPLES_PER_ITEM; i++) begin
            lane_x[i] = SW'(sample_at(s_data, i));
        end
    end

    for (genvar g = 0; g < SAMPLES_PER_ITEM; g++) begin : g_lane
        ble_rank_lane #(
            .N      (SAMPLES_PER_ITEM),
            .SW     (SW),
            .RANK_W (RANK_W),
            .IDX    (g)
        ) u_lane (
            .aclk       (aclk),
            .load       (stage_load[ST_RANK]),
            .samples    (lane_x),
            .sample_reg (lane_sample[g]),
            .rank_reg   (lane_rank[g])
        );
    end

    // ---- merge lanes into the median ----
    logic [SW-1:0] median_reg;

    ble_median_merge #(
        .N      (SAMPLES_PER_ITEM),
        .SW     (SW),
        .RANK_W (RANK_W)
    ) u_merge (
        .aclk       (aclk),
        .load       (stage_load[ST_MEDIAN]),
        .samples    (lane_sample),
        .ranks      (lane_rank),
        .median_reg (median_reg)
    );

    // ---- scale the median code to volts ----
    logic [VOLT_W-1:0] volt_fix;
    logic [SW-1:0]     median_fix;

    ble_volt_scale #(
        .ADC_BITS (ADC_BITS),
        .SW       (SW)
    ) u_scale (
        .est_ctl    (ctl[ST_EST]),
        .fix_ctl    (ctl[ST_FIX]),
        .aclk       (aclk),
        .median     (median_reg),
        .volt_reg   (volt_fix),
        .median_reg (median_fix)
    );

    // ---- EMA, percent, report; the last stage is the output register ----
    out_item_t out_reg;

    ble_level_track u_track (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ema_ctl           (ctl[ST_EMA]),
        .pct_ctl           (ctl[ST_PCT]),
        .out_ctl           (ctl[ST_OUT]),
        .smooth_weight     (alpha_reg),
        .report_hysteresis (hyst_reg),
        .notify_enable     (notify_en_reg),
        .volt_in           (volt_fix),
        .median_in         (FIELD_W'(median_fix)),
        .sink_present      (sink_reg[ST_PCT]),
        .link_connected    (link_reg[ST_PCT]),
        .out_reg           (out_reg)
    );

    assign m_data = out_reg;

    // ---- checks ----
    `BLE_ASSERT_NOW(a_pct_range, aclk, aresetn, m_valid, m_data.percent <= PCT_FULL)
    `BLE_ASSERT_NOW(a_volt_range, aclk, aresetn, m_valid, m_data.filtered_voltage <= VOLT_MAX)
    `BLE_ASSERT_NOW(a_notify_needs_report, aclk, aresetn, m_valid && m_data.notify, m_data.report)
    `BLE_ASSERT_NOW(a_full_stall_blocks_input, aclk, aresetn, (&vld_reg) && !m_ready, !s_ready)
    `BLE_ASSERT_NEXT(a_full_stall_keeps_items, aclk, aresetn, (&vld_reg) && !m_ready, &vld_reg)

endmodule

[tb/battery_level_estimator_top_test.sv]
// Self-checking testbench for battery_level_estimator_top: a scoreboard class predicts each
// result from the accepted sample beats; plain tasks drive the input and register channels.
// Depends on ble_pkg and the battery_level_estimator_top RTL.
module battery_level_estimator_top_test;
    import ble_pkg::*;

    // Scoreboard: owns a private copy of the filter/report state and the registers,
    // turns every accepted input beat into one expected result and checks results in order.
    class level_scoreboard;
        logic [ALPHA_W-1:0] alpha;
        logic [HYST_W-1:0]  hyst;
        logic               notify_en;
        logic [VOLT_W-1:0]  ema;
        bit                 seeded;
        logic [PCT_W-1:0]   last_pct;
        bit                 reported;
        out_item_t          expected_q[$];
        int                 mismatches;

        function new();
            alpha      = ALPHA_RESET;
            hyst       = HYST_RESET;
            notify_en  = NOTIFY_EN_RESET;
            ema        = '0;
            seeded     = 0;
            last_pct   = '0;
            reported   = 0;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_SMOOTH_WEIGHT: alpha     = d[ALPHA_W-1:0];
                CFG_REPORT_HYST:   hyst      = d[HYST_W-1:0];
                CFG_NOTIFY_EN:     notify_en = d[0];
                default: ;
            endcase
        endfunction

        function sample_t median9(in_item_t it);
            sample_t s[SAMPLE_FIELDS];
            sample_t t;
            s[0] = it.sample_0; s[1] = it.sample_1; s[2] = it.sample_2;
            s[3] = it.sample_3; s[4] = it.sample_4; s[5] = it.sample_5;
            s[6] = it.sample_6; s[7] = it.sample_7; s[8] = it.sample_8;
            for (int i = 0; i < SAMPLE_FIELDS - 1; i++) begin
                for (int j = 0; j < SAMPLE_FIELDS - 1 - i; j++) begin
                    if (s[j] > s[j+1]) begin
                        t = s[j]; s[j] = s[j+1]; s[j+1] = t;
                    end
                end
            end
            return s[SAMPLE_FIELDS/2];
        endfunction

        // Piecewise map: 0 at or below 3.30 V, 100 at or above 4.15 V, knee at 3.80 V.
        function logic [PCT_W-1:0] volts_to_percent(logic [VOLT_W-1:0] v);
            logic [63:0] x;
            logic [63:0] q;
            x = 64'(v);
            if (x * 64'd20 >= 64'd83 * 64'd65536) return PCT_FULL;
            if (x * 64'd10 <= 64'd33 * 64'd65536) return '0;
            if (x * 64'd5 > 64'd19 * 64'd65536) begin
                q = ((x * 64'd5 - 64'd19 * 64'd65536) * 64'd200) / (64'd7 * 64'd65536);
                return PCT_MID + q[PCT_W-1:0];
            end
            q = ((x * 64'd10 - 64'd33 * 64'd65536) * 64'd10) / 64'd65536;
            return q[PCT_W-1:0];
        endfunction

        function void note_input(in_item_t it);
            out_item_t        r;
            sample_t          med;
            logic [63:0]      vnow;
            logic [63:0]      acc;
            logic [PCT_W-1:0] pct;
            logic [PCT_W-1:0] diff;
            med  = median9(it);
            vnow = (64'(med) * 64'd33 * 64'd65536) / (64'd5 * ((64'd1 << ADC_BITS_DEF) - 1));
            if (!seeded) begin
                ema    = vnow[VOLT_W-1:0];
                seeded = 1;
            end else begin
                acc = (64'd65536 - 64'(alpha)) * 64'(ema) + 64'(alpha) * vnow + 64'd32768;
                ema = acc[FRAC_BITS +: VOLT_W];
            end
            pct  = volts_to_percent(ema);
            diff = (pct >= last_pct) ? pct - last_pct : last_pct - pct;
            r.percent          = pct;
            r.filtered_voltage = ema;
            r.median_sample    = med;
            r.report           = 1'b0;
            r.notify           = 1'b0;
            if ((!reported || diff >= hyst) && it.sink_present) begin
                r.report = 1'b1;
                r.notify = notify_en & it.link_connected;
                last_pct = pct;
                reported = 1;
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: pct=%0d v=%0d med=%0d rep=%0b ntf=%0b",
                             got.percent, got.filtered_voltage, got.median_sample,
                             got.report, got.notify);
                return;
            end
            want = expected_q.pop_front();
            if (got.percent !== want.percent ||
                got.filtered_voltage !== want.filtered_voltage ||
                got.median_sample !== want.median_sample ||
                got.report !== want.report || got.notify !== want.notify) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch: expected pct=%0d v=%0d med=%0d rep=%0b ntf=%0b",
                             want.percent, want.filtered_voltage, want.median_sample,
                             want.report, want.notify);
                    $display("                 got      pct=%0d v=%0d med=%0d rep=%0b ntf=%0b",
                             got.percent, got.filtered_voltage, got.median_sample,
                             got.report, got.notify);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    level_scoreboard sb;
    bit              hold_req;    // ask the result sink for a long back-pressure stretch
    int              walk_level;  // slowly drifting raw level the random beats center on

    battery_level_estimator_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs; far beyond the slowest legal run.
    initial begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end

    // Build one beat from nine raw codes and the two status bits.
    function automatic in_item_t make_item(sample_t smp[SAMPLE_FIELDS], bit sink, bit link);
        in_item_t it;
        it.sample_0 = smp[0]; it.sample_1 = smp[1]; it.sample_2 = smp[2];
        it.sample_3 = smp[3]; it.sample_4 = smp[4]; it.sample_5 = smp[5];
        it.sample_6 = smp[6]; it.sample_7 = smp[7]; it.sample_8 = smp[8];
        it.sink_present   = sink;
        it.link_connected = link;
        return it;
    endfunction

    function automatic in_item_t flat_item(int raw, bit sink, bit link);
        sample_t smp[SAMPLE_FIELDS];
        foreach (smp[i]) smp[i] = sample_t'(raw);
        return make_item(smp, sink, link);
    endfunction

    // Mostly a noisy cluster around the drifting level with a few outliers; one beat in
    // ten is pure noise over the whole code range.
    function automatic in_item_t random_item();
        sample_t smp[SAMPLE_FIELDS];
        int      v;
        bit      noise;
        noise = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 49) == 0)
            walk_level = $urandom_range(0, 4095);
        else
            walk_level = walk_level + $urandom_range(0, 40) - 20;
        if (walk_level < 1900) walk_level = 1900 + $urandom_range(0, 20);
        if (walk_level > 2700) walk_level = 2700 - $urandom_range(0, 20);
        foreach (smp[i]) begin
            if (noise || $urandom_range(0, 99) < 8) begin
                smp[i] = sample_t'($urandom_range(0, 4095));
            end else begin
                v = walk_level + $urandom_range(0, 32) - 16;
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
                smp[i] = sample_t'(v);
            end
        end
        return make_item(smp, $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)));
    endfunction

    // Offer one beat and hold it until the block takes it; valid stays up on return.
    task automatic send_item(in_item_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
    endtask

    // Write one register, then drop valid and idle the channel before the next write.
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, d);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Drop valid and wait for every outstanding result, so registers are safe to write.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic set_all(logic [ALPHA_W-1:0] a, logic [HYST_W-1:0] h, bit n);
        drain();
        write_reg(CFG_SMOOTH_WEIGHT, a);
        // Upper bits of the narrow registers are junk the block must ignore.
        write_reg(CFG_REPORT_HYST, {9'($urandom), h});
        write_reg(CFG_NOTIFY_EN, {15'($urandom), n});
    endtask

    task automatic run_directed();
        sample_t smp[SAMPLE_FIELDS];
        // First beat seeds the filter at zero volts and always reports.
        send_item(flat_item(0, 1, 1));
        send_item(flat_item(4095, 1, 1));
        send_item(flat_item(4095, 0, 1));   // no sink: report state must hold
        smp = '{12'd0, 12'd500, 12'd1000, 12'd1500, 12'd2000, 12'd2500, 12'd3000,
                12'd3500, 12'd4000};
        send_item(make_item(smp, 1, 0));
        smp = '{12'd4000, 12'd3500, 12'd3000, 12'd2500, 12'd2000, 12'd1500, 12'd1000,
                12'd500, 12'd0};
        send_item(make_item(smp, 1, 1));
        smp = '{12'd7, 12'd7, 12'd7, 12'd3, 12'd3, 12'd3, 12'd9, 12'd9, 12'd9};
        send_item(make_item(smp, 1, 1));
        smp = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
                12'd4095};
        send_item(make_item(smp, 1, 1));
        smp = '{12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA,
                12'h555, 12'hAAA};
        send_item(make_item(smp, 1, 1));

        // Near-unity alpha and zero hysteresis: every percent boundary reports directly.
        set_all(16'hFFFF, 7'd0, 1'b1);
        send_item(flat_item(2047, 1, 1));   // just under 3.30 V
        send_item(flat_item(2048, 1, 1));
        send_item(flat_item(2357, 1, 1));   // around the 3.80 V knee
        send_item(flat_item(2358, 1, 1));
        send_item(flat_item(2575, 1, 1));   // around 4.15 V
        send_item(flat_item(2576, 1, 0));
        send_item(flat_item(2400, 0, 1));

        // Notify disabled, then hysteresis above the whole range.
        set_all(16'hFFFF, 7'd0, 1'b0);
        send_item(flat_item(2200, 1, 1));
        set_all(16'hFFFF, 7'd127, 1'b1);
        send_item(flat_item(0, 1, 1));
        send_item(flat_item(4095, 1, 1));

        // Zero alpha freezes the filter whatever the samples do.
        set_all(16'h0000, 7'd100, 1'b1);
        send_item(flat_item(4095, 1, 1));
        send_item(flat_item(0, 1, 1));
    endtask

    // One phase of random traffic in bursts; gap_max of zero means no idling at all.
    task automatic run_phase(int count, int gap_max, bit want_hold);
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 40);
        for (int i = 0; i < count; i++) begin
            if (want_hold && i == 30) hold_req = 1;
            if (burst_left == 0) begin
                gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            send_item(random_item());
        end
    endtask

    // Stimulus: reset, directed corners, then phases under different register settings.
    initial begin
        sb         = new();
        hold_req   = 0;
        walk_level = 2300;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SMOOTH_WEIGHT;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        for (int p = 0; p < 10; p++) begin
            case (p)
                0: set_all(ALPHA_RESET, HYST_RESET, 1'b1);
                1: set_all(16'hFFFF, 7'd0, 1'b1);
                2: set_all(16'h0000, 7'd1, 1'b0);
                3: set_all(16'($urandom), 7'd100, 1'b1);
                4: set_all(16'h0001, 7'd127, 1'b1);
                default: set_all(16'($urandom), 7'($urandom_range(0, 10)),
                                 1'($urandom_range(0, 1)));
            endcase
            run_phase(115, (p % 3 == 0) ? 0 : 8, p == 2 || p == 6);
        end

        drain();
        // Let any stray beat surface before judging.
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Result sink: check every accepted beat, and stall on its own pattern. Modes change
    // at random intervals; a hold request forces ready low for a long counted stretch
    // so the pipeline fills and back-pressures the input.
    initial begin : result_sink
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        m_ready  <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_data);
            tick++;
            if (hold_req) begin
                hold_left = 150;
                hold_req  = 0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= ($urandom_range(0, 9) < 3);
                    default: m_ready <= (tick % 4 == 0);
                endcase
            end
        end
    end

endmodule
